[rtl/deq_pkg.sv]
// Package: widths, request and status codes, and controller states for the deque.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 64;
   localparam int TYPE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 5;

   typedef enum logic [TYPE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_SEARCH     = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN
   } state_type;

endpackage

[rtl/deq_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface deq_req_if
   import deq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [VALUE_W-1:0]  item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  out_value;
   logic                found;
   logic [STATUS_W-1:0] status;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output out_value, output found, output status,
                   output fill_count, input ready);
   modport sink   (input valid, input out_value, input found, input status,
                   input fill_count, output ready);
endinterface

[rtl/deq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module deq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/double_ended_queue_with_search_unit.sv]
// Top level: double-ended queue of 64-bit words in a circular RAM, with membership search.
//
// Usage:
//   req_chan carries one request word: req_type selects push back/front, pop front/back,
//   peek front/back or search; item_value is the word to push or to look for.
//   rsp_chan returns exactly one response word per request: out_value (popped or peeked
//   word, else zero), found (search hit), status (ok / empty / full) and fill_count
//   (entries held after the request, low five bits).
//   One request is worked on at a time. A pop or peek with data takes one RAM read, registered;
//   a search compares one stored word per cycle through the single read port of the entry RAM,
//   walking from the front toward the back, and compares at most DEPTH entries.
//   Reset (synchronous, active high) empties the queue; RAM contents are left as they are
//   and only held entries are ever read. rsp_chan has its own output register: a new
//   request is taken while a response waits, and the block holds its finished result
//   (and any pointer or RAM update of a push) until that register frees up.
module double_ended_queue_with_search_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Circular buffer slot for a sum below 2*DEPTH.
   function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [IDX_W-1:0] r;
      if (s >= SUM_W'(DEPTH)) begin
         r = IDX_W'(s - SUM_W'(DEPTH));
      end else begin
         r = IDX_W'(s);
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TYPE_W-1:0]    op_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic [IDX_W-1:0]     scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;

   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_found_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [FILL_W-1:0]    rsp_fill_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 is_full, is_empty;
   logic                 scan_hit, scan_end;

   logic [IDX_W-1:0]     back_slot, last_slot, front_prev, front_next, scan_next;

   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   logic                 fin_valid;
   logic [VALUE_W-1:0]   fin_value;
   logic                 fin_found;
   status_type           fin_status;
   logic [CNT_W-1:0]     fin_count;
   logic                 fin_load;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fin_load       = fin_valid & out_free;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Slot arithmetic around the ring
   assign back_slot  = wrap_slot(SUM_W'(front_ff) + SUM_W'(count_ff));
   assign last_slot  = wrap_slot(SUM_W'(front_ff) + SUM_W'(count_ff) - SUM_W'(1));
   assign front_prev = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_next = wrap_slot(SUM_W'(front_ff) + SUM_W'(1));
   assign scan_next  = wrap_slot(SUM_W'(scan_slot_ff) + SUM_W'(1));

   // Search: compare the word read last cycle; stop on a hit or after the back entry
   assign scan_hit = (ram_rd_data == val_ff);
   assign scan_end = scan_hit || (scan_idx_ff == count_ff);

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (val_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                  if (!is_empty) state_in = ST_READ;
                  else if (out_free) state_in = ST_IDLE;
               end
               OP_SEARCH: begin
                  if (!is_empty) state_in = ST_SCAN;
                  else if (out_free) state_in = ST_IDLE;
               end
               default: begin
                  if (out_free) state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_end && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control: RAM access, pointer updates and the finished result
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = back_slot;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = front_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      scan_slot_in = scan_slot_ff;
      scan_idx_in  = scan_idx_ff;
      fin_valid    = 1'b0;
      fin_value    = '0;
      fin_found    = 1'b0;
      fin_status   = STAT_OK;
      fin_count    = count_ff;
      case (state_ff)
         ST_EXEC: begin
            case (op_ff)
               OP_PUSH_BACK, OP_PUSH_FRONT: begin
                  fin_valid = 1'b1;
                  if (is_full) begin
                     fin_status = STAT_FULL;
                  end else begin
                     fin_count = count_ff + CNT_W'(1);
                     // commit only together with the response
                     if (out_free) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        if (op_ff == OP_PUSH_FRONT) begin
                           ram_wr_addr = front_prev;
                           front_in    = front_prev;
                        end
                     end
                  end
               end
               OP_POP_FRONT, OP_PEEK_FRONT: begin
                  if (is_empty) begin
                     fin_valid  = 1'b1;
                     fin_status = STAT_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = front_ff;
                     if (op_ff == OP_POP_FRONT) begin
                        front_in = front_next;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               OP_POP_BACK, OP_PEEK_BACK: begin
                  if (is_empty) begin
                     fin_valid  = 1'b1;
                     fin_status = STAT_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = last_slot;
                     if (op_ff == OP_POP_BACK) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
               end
               OP_SEARCH: begin
                  if (is_empty) begin
                     fin_valid = 1'b1;
                  end else begin
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = front_ff;
                     scan_slot_in = front_next;
                     scan_idx_in  = CNT_W'(1);
                  end
               end
               default: begin
                  fin_valid = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            fin_valid = 1'b1;
            fin_value = ram_rd_data;
         end
         ST_SCAN: begin
            if (scan_end) begin
               fin_valid = 1'b1;
               fin_found = scan_hit;
            end else begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = scan_slot_ff;
               scan_slot_in = scan_next;
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_chan.req_type;
         val_ff <= req_chan.item_value;
      end
      scan_slot_ff <= scan_slot_in;
      scan_idx_ff  <= scan_idx_in;
      if (fin_load) begin
         rsp_value_ff  <= fin_value;
         rsp_found_ff  <= fin_found;
         rsp_status_ff <= fin_status;
         rsp_fill_ff   <= FILL_W'(fin_count);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_value  = rsp_value_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;

   // Checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_front_bound : assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(DEPTH - 1))
      else $error("front slot out of range");

   a_write_in_exec : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_EXEC) && out_free && !is_full)
      else $error("entry write outside a committed push");

   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed next cycle");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !is_empty && (op_ff == OP_POP_FRONT || op_ff == OP_POP_BACK))
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not reduce the count by one");

endmodule
